>>> rtl/pfa_pkg.sv
`timescale 1ns / 1ps

package pfa_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_FREE   = 3'd2;
    localparam logic [2:0] OP_INCREF = 3'd3;
    localparam logic [2:0] OP_DECREF = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_NO_MEMORY = 3'd1;
    localparam logic [2:0] STS_BAD_FREE  = 3'd2;
    localparam logic [2:0] STS_UNDERFLOW = 3'd3;
    localparam logic [2:0] STS_SATURATED = 3'd4;
    localparam logic [2:0] STS_BAD_INDEX = 3'd5;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_PAGE_COUNT = 3'd0;
    localparam logic [2:0] REG_IO_FIRST   = 3'd1;
    localparam logic [2:0] REG_IO_LAST    = 3'd2;
    localparam logic [2:0] REG_KERN_FIRST = 3'd3;
    localparam logic [2:0] REG_KERN_LAST  = 3'd4;
    localparam logic [2:0] REG_MP_ENTRY   = 3'd5;

    localparam logic [12:0] RST_PAGE_COUNT = 13'd4096;
    localparam logic [11:0] RST_IO_FIRST   = 12'd160;
    localparam logic [11:0] RST_IO_LAST    = 12'd256;
    localparam logic [11:0] RST_KERN_FIRST = 12'd256;
    localparam logic [11:0] RST_KERN_LAST  = 12'd512;
    localparam logic [11:0] RST_MP_ENTRY   = 12'd7;

    typedef struct packed {
        logic [12:0] page_count;
        logic [11:0] io_first;
        logic [11:0] io_last;
        logic [11:0] kern_first;
        logic [11:0] kern_last;
        logic [11:0] mp_entry;
    } t_cfg;

    typedef struct packed {
        logic val_zero;
        logic val_max;
        logic res_zero;
    } t_alu_flags;

    typedef struct packed {
        logic in_range;
        logic reserved;
    } t_page_class;

endpackage

>>> rtl/pfa_regs.sv
`timescale 1ns / 1ps

module pfa_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output pfa_pkg::t_cfg      o_cfg
);

    pfa_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_count <= pfa_pkg::RST_PAGE_COUNT;
            r_cfg.io_first   <= pfa_pkg::RST_IO_FIRST;
            r_cfg.io_last    <= pfa_pkg::RST_IO_LAST;
            r_cfg.kern_first <= pfa_pkg::RST_KERN_FIRST;
            r_cfg.kern_last  <= pfa_pkg::RST_KERN_LAST;
            r_cfg.mp_entry   <= pfa_pkg::RST_MP_ENTRY;
        end else if (w_wr) begin
            case (w_idx)
                pfa_pkg::REG_PAGE_COUNT: r_cfg.page_count <= pwdata[12:0];
                pfa_pkg::REG_IO_FIRST:   r_cfg.io_first   <= pwdata[11:0];
                pfa_pkg::REG_IO_LAST:    r_cfg.io_last    <= pwdata[11:0];
                pfa_pkg::REG_KERN_FIRST: r_cfg.kern_first <= pwdata[11:0];
                pfa_pkg::REG_KERN_LAST:  r_cfg.kern_last  <= pwdata[11:0];
                pfa_pkg::REG_MP_ENTRY:   r_cfg.mp_entry   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pfa_pkg::REG_PAGE_COUNT: prdata = {19'd0, r_cfg.page_count};
            pfa_pkg::REG_IO_FIRST:   prdata = {20'd0, r_cfg.io_first};
            pfa_pkg::REG_IO_LAST:    prdata = {20'd0, r_cfg.io_last};
            pfa_pkg::REG_KERN_FIRST: prdata = {20'd0, r_cfg.kern_first};
            pfa_pkg::REG_KERN_LAST:  prdata = {20'd0, r_cfg.kern_last};
            pfa_pkg::REG_MP_ENTRY:   prdata = {20'd0, r_cfg.mp_entry};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/pfa_alu.sv
`timescale 1ns / 1ps

module pfa_alu #(
    parameter int REF_BITS = 16
) (
    input  logic [REF_BITS-1:0]  i_value,
    input  logic                 i_dec,
    output logic [REF_BITS-1:0]  o_result,
    output pfa_pkg::t_alu_flags  o_flags
);

    // One adder serves both increment and decrement of a reference count.
    assign o_result         = i_dec ? (i_value - REF_BITS'(1)) : (i_value + REF_BITS'(1));
    assign o_flags.val_zero = (i_value == '0);
    assign o_flags.val_max  = &i_value;
    assign o_flags.res_zero = (o_result == '0);

endmodule

>>> rtl/pfa_class.sv
`timescale 1ns / 1ps

module pfa_class #(
    parameter int PAGES = 4096
) (
    input  logic [$clog2(PAGES)-1:0] i_page,
    input  pfa_pkg::t_cfg            i_cfg,
    output pfa_pkg::t_page_class     o_class
);

    localparam int PW = $clog2(PAGES);
    localparam int LW = (PW + 1 > 13) ? PW + 1 : 13;

    logic [LW-1:0] w_pg;

    assign w_pg = LW'(i_page);

    assign o_class.in_range = (w_pg < LW'(i_cfg.page_count));
    assign o_class.reserved = (w_pg == '0)
        || ((w_pg >= LW'(i_cfg.io_first)) && (w_pg <= LW'(i_cfg.io_last)))
        || ((w_pg >= LW'(i_cfg.kern_first)) && (w_pg <= LW'(i_cfg.kern_last)))
        || (w_pg == LW'(i_cfg.mp_entry));

endmodule

>>> rtl/page_frame_allocator_refcount.sv
`timescale 1ns / 1ps
// Channel  | Direction | Signals                           | Contents
// s_axis   | in        | tvalid tready tdata[15:0] tuser   | page_index ; opcode in tuser
// m_axis   | out       | tvalid tready tdata[31:0] tuser   | page, count, freed ; status
// apb      | in        | psel penable pwrite paddr pwdata  | six configuration registers
//
// Alloc, free, incref and decref: the transfer cycle reads the page's count/free word and link;
// ST_EXEC, once the output register is free, updates the word (incref and decref share one adder)
// and writes it back. Init makes one count-word write per page, in ascending order.
// After reset a clearing pass writes all PAGES count words to zero; no transfer is
// accepted during that pass, though register writes are.
// A result waits in the output register; a finished operation stalls only while it is full.

module page_frame_allocator_refcount #(
    parameter int PAGES    = 4096,
    parameter int REF_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] page_index, [15:12] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [11:0] result_page, [27:12] ref_count,
                                        // [28] freed, [31:29] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(PAGES);
    localparam int LW = (PW + 1 > 13) ? PW + 1 : 13;
    localparam logic [PW-1:0] LAST_IDX = PW'(PAGES - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    pfa_pkg::t_cfg        w_cfg;
    pfa_pkg::t_alu_flags  w_flags;
    pfa_pkg::t_page_class w_class;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_idx, n_idx;
    logic [2:0]         r_op, n_op;
    logic [11:0]        r_page, n_page;
    logic [PW-1:0]      r_head, n_head;
    logic               r_nonempty, n_nonempty;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_status, n_out_status;
    logic [11:0]        r_out_page, n_out_page;
    logic [15:0]        r_out_count, n_out_count;
    logic               r_out_freed, n_out_freed;

    // Each count word holds the free flag above the reference count.
    logic [REF_BITS:0]  r_cnt_mem [PAGES];
    logic [PW-1:0]      r_link_mem [PAGES];
    logic [REF_BITS:0]  r_rd_word;
    logic [PW-1:0]      r_rd_link;

    logic               w_accept;
    logic               w_out_free;
    logic [PW-1:0]      w_rd_addr;
    logic [PW-1:0]      w_wr_addr;
    logic [REF_BITS:0]  w_wr_word;
    logic               w_cnt_we;
    logic               w_push;
    logic [PW-1:0]      w_link_data;
    logic [REF_BITS-1:0] w_rd_cnt;
    logic               w_rd_free;
    logic [REF_BITS-1:0] w_alu_res;
    logic               w_bad;
    logic [PW-1:0]      w_page_ext;

    pfa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pfa_alu #(.REF_BITS(REF_BITS)) u_alu (
        .i_value  (w_rd_cnt),
        .i_dec    (r_op == pfa_pkg::OP_DECREF),
        .o_result (w_alu_res),
        .o_flags  (w_flags)
    );

    pfa_class #(.PAGES(PAGES)) u_class (
        .i_page  (r_idx),
        .i_cfg   (w_cfg),
        .o_class (w_class)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_rd_addr     = (s_axis_tuser == pfa_pkg::OP_ALLOC) ? r_head : PW'(s_axis_tdata[11:0]);
    assign w_rd_cnt      = r_rd_word[REF_BITS-1:0];
    assign w_rd_free     = r_rd_word[REF_BITS];
    assign w_page_ext    = PW'(r_page);
    assign w_bad         = (LW'(r_page) >= LW'(w_cfg.page_count)) || (LW'(r_page) >= LW'(PAGES));
    assign w_link_data   = r_nonempty ? r_head : w_wr_addr;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'd0, r_out_freed, r_out_count, r_out_page};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_word <= r_cnt_mem[w_rd_addr];
            r_rd_link <= r_link_mem[w_rd_addr];
        end
        if (w_cnt_we) begin
            r_cnt_mem[w_wr_addr] <= w_wr_word;
        end
        if (w_push) begin
            r_link_mem[w_wr_addr] <= w_link_data;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_op         = r_op;
        n_page       = r_page;
        n_head       = r_head;
        n_nonempty   = r_nonempty;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_count  = r_out_count;
        n_out_freed  = r_out_freed;
        w_cnt_we     = 1'b0;
        w_push       = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_word    = '0;

        case (r_state)
            ST_CLEAR: begin
                w_cnt_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_op   = s_axis_tuser;
                    n_page = s_axis_tdata[11:0];
                    if (s_axis_tuser == pfa_pkg::OP_INIT) begin
                        n_idx      = '0;
                        n_head     = '0;
                        n_nonempty = 1'b0;
                        n_state    = ST_SWEEP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_SWEEP: begin
                // Pages past the managed count are cleared as well, so the walk is always
                // the whole memory.
                w_cnt_we = 1'b1;
                if (w_class.in_range && w_class.reserved) begin
                    w_wr_word = {1'b0, REF_BITS'(1)};
                end else if (w_class.in_range) begin
                    w_wr_word  = {1'b1, {REF_BITS{1'b0}}};
                    w_push     = 1'b1;
                    n_head     = r_idx;
                    n_nonempty = 1'b1;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = pfa_pkg::STS_OK;
                    n_out_page   = r_nonempty ? 12'(r_head) : 12'd0;
                    n_out_count  = 16'd0;
                    n_out_freed  = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = pfa_pkg::STS_OK;
                    n_out_page   = r_page;
                    n_out_count  = 16'd0;
                    n_out_freed  = 1'b0;
                    n_state      = ST_IDLE;
                    w_wr_addr    = w_page_ext;
                    case (r_op)
                        pfa_pkg::OP_ALLOC: begin
                            n_out_page = 12'd0;
                            if (!r_nonempty) begin
                                n_out_status = pfa_pkg::STS_NO_MEMORY;
                            end else begin
                                // The bottom entry links to itself.
                                w_wr_addr   = r_head;
                                w_cnt_we    = 1'b1;
                                w_wr_word   = {1'b0, w_rd_cnt};
                                n_out_page  = 12'(r_head);
                                n_out_count = 16'(w_rd_cnt);
                                if (r_rd_link == r_head) begin
                                    n_nonempty = 1'b0;
                                end else begin
                                    n_head = r_rd_link;
                                end
                            end
                        end
                        pfa_pkg::OP_FREE: begin
                            if (w_bad) begin
                                n_out_status = pfa_pkg::STS_BAD_INDEX;
                            end else if (!w_flags.val_zero || w_rd_free) begin
                                n_out_status = pfa_pkg::STS_BAD_FREE;
                                n_out_count  = 16'(w_rd_cnt);
                            end else begin
                                w_cnt_we    = 1'b1;
                                w_wr_word   = {1'b1, {REF_BITS{1'b0}}};
                                w_push      = 1'b1;
                                n_head      = w_page_ext;
                                n_nonempty  = 1'b1;
                                n_out_freed = 1'b1;
                            end
                        end
                        pfa_pkg::OP_INCREF: begin
                            if (w_bad) begin
                                n_out_status = pfa_pkg::STS_BAD_INDEX;
                            end else if (w_flags.val_max) begin
                                n_out_status = pfa_pkg::STS_SATURATED;
                                n_out_count  = 16'(w_rd_cnt);
                            end else begin
                                w_cnt_we    = 1'b1;
                                w_wr_word   = {w_rd_free, w_alu_res};
                                n_out_count = 16'(w_alu_res);
                            end
                        end
                        pfa_pkg::OP_DECREF: begin
                            if (w_bad) begin
                                n_out_status = pfa_pkg::STS_BAD_INDEX;
                            end else if (w_flags.val_zero) begin
                                n_out_status = pfa_pkg::STS_UNDERFLOW;
                            end else if (!w_flags.res_zero) begin
                                w_cnt_we    = 1'b1;
                                w_wr_word   = {w_rd_free, w_alu_res};
                                n_out_count = 16'(w_alu_res);
                            end else if (w_rd_free) begin
                                // Reached zero while already on the list: not pushed twice.
                                w_cnt_we     = 1'b1;
                                w_wr_word    = {1'b1, {REF_BITS{1'b0}}};
                                n_out_status = pfa_pkg::STS_BAD_FREE;
                            end else begin
                                w_cnt_we    = 1'b1;
                                w_wr_word   = {1'b1, {REF_BITS{1'b0}}};
                                w_push      = 1'b1;
                                n_head      = w_page_ext;
                                n_nonempty  = 1'b1;
                                n_out_freed = 1'b1;
                            end
                        end
                        default: begin
                            n_out_page = 12'd0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_head      <= '0;
            r_nonempty  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_head      <= n_head;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_page       <= n_page;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_count  <= n_out_count;
        r_out_freed  <= n_out_freed;
    end

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC) || (r_state == ST_SWEEP))
        else $error("accepted transfer did not start an operation");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_cnt_we && !w_push)
        else $error("memory written while idle");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_nonempty)
        else $error("free list empty after a push");

    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_freed) |-> (r_out_status == pfa_pkg::STS_OK))
        else $error("freed result carries a fault status");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int PAGES = 4096;
    localparam int REF_BITS = 16;
    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] page;
        logic [15:0] count;
        logic        freed;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    page_frame_allocator_refcount #(
        .PAGES    (PAGES),
        .REF_BITS (REF_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the allocator: counts, free flags, links and list head.
    pfa_pkg::t_cfg   cfg = {pfa_pkg::RST_PAGE_COUNT, pfa_pkg::RST_IO_FIRST,
                            pfa_pkg::RST_IO_LAST, pfa_pkg::RST_KERN_FIRST,
                            pfa_pkg::RST_KERN_LAST, pfa_pkg::RST_MP_ENTRY};
    bit [15:0]       pf_count [PAGES];
    bit [11:0]       pf_link [PAGES];
    bit              pf_free [PAGES];
    bit [11:0]       pf_head;
    bit              pf_nonempty;

    t_result         awaited_results [$];
    logic [11:0]     held_pages [$];

    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    int              mismatches = 0;
    int              items_sent = 0;
    int              results_seen = 0;
    int              inits_sent = 0;
    int              reg_writes = 0;
    int              traffic_phases = 0;
    int unsigned     cycle_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic bit page_reserved(input int unsigned pg);
        if (pg == 0) return 1'b1;
        if (pg >= cfg.io_first && pg <= cfg.io_last) return 1'b1;
        if (pg >= cfg.kern_first && pg <= cfg.kern_last) return 1'b1;
        return pg == cfg.mp_entry;
    endfunction

    function automatic void push_free_page(input logic [11:0] pg);
        pf_link[pg] = pf_nonempty ? pf_head : pg;
        pf_head = pg;
        pf_nonempty = 1'b1;
        pf_free[pg] = 1'b1;
    endfunction

    function automatic t_result predict_alloc_op(input logic [2:0] op,
                                                 input logic [11:0] pg);
        t_result r;
        int unsigned lim;
        logic [11:0] h;
        r = '0;
        lim = (cfg.page_count < PAGES) ? cfg.page_count : PAGES;
        case (op)
            pfa_pkg::OP_INIT: begin
                for (int i = 0; i < PAGES; i++) begin
                    pf_count[i] = '0;
                    pf_free[i] = 1'b0;
                end
                pf_head = '0;
                pf_nonempty = 1'b0;
                for (int i = 0; i < lim; i++) begin
                    if (page_reserved(i))
                        pf_count[i] = 16'd1;
                    else
                        push_free_page(12'(i));
                end
                r.page = pf_nonempty ? pf_head : 12'd0;
            end
            pfa_pkg::OP_ALLOC: begin
                if (!pf_nonempty) begin
                    r.status = pfa_pkg::STS_NO_MEMORY;
                end else begin
                    h = pf_head;
                    if (pf_link[h] == h)
                        pf_nonempty = 1'b0;
                    else
                        pf_head = pf_link[h];
                    pf_free[h] = 1'b0;
                    r.page = h;
                    r.count = pf_count[h];
                end
            end
            pfa_pkg::OP_FREE, pfa_pkg::OP_INCREF, pfa_pkg::OP_DECREF: begin
                r.page = pg;
                if (pg >= lim) begin
                    r.status = pfa_pkg::STS_BAD_INDEX;
                end else if (op == pfa_pkg::OP_FREE) begin
                    r.count = pf_count[pg];
                    if (pf_count[pg] != 0 || pf_free[pg]) begin
                        r.status = pfa_pkg::STS_BAD_FREE;
                    end else begin
                        push_free_page(pg);
                        r.freed = 1'b1;
                    end
                end else if (op == pfa_pkg::OP_INCREF) begin
                    if (pf_count[pg] >= REF_MAX) begin
                        r.status = pfa_pkg::STS_SATURATED;
                    end else begin
                        pf_count[pg]++;
                    end
                    r.count = pf_count[pg];
                end else if (pf_count[pg] == 0) begin
                    r.status = pfa_pkg::STS_UNDERFLOW;
                end else begin
                    pf_count[pg]--;
                    r.count = pf_count[pg];
                    // Reaching zero frees the page unless it is already on the list.
                    if (pf_count[pg] == 0) begin
                        if (pf_free[pg]) begin
                            r.status = pfa_pkg::STS_BAD_FREE;
                        end else begin
                            push_free_page(pg);
                            r.freed = 1'b1;
                        end
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [11:0] pg,
                             output t_result outcome);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, pg};
        do @(posedge i_clk); while (!s_axis_tready);
        outcome = predict_alloc_op(op, pg);
        awaited_results.push_back(outcome);
        items_sent++;
        if (op == pfa_pkg::OP_INIT) begin
            inits_sent++;
            held_pages.delete();
        end
        if (op == pfa_pkg::OP_ALLOC && outcome.status == pfa_pkg::STS_OK
            && held_pages.size() < 64)
            held_pages.push_back(outcome.page);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == pfa_pkg::REG_PAGE_COUNT) ? 32'h1FFF : 32'h0FFF;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            pfa_pkg::REG_PAGE_COUNT: cfg.page_count = val[12:0];
            pfa_pkg::REG_IO_FIRST:   cfg.io_first   = val[11:0];
            pfa_pkg::REG_IO_LAST:    cfg.io_last    = val[11:0];
            pfa_pkg::REG_KERN_FIRST: cfg.kern_first = val[11:0];
            pfa_pkg::REG_KERN_LAST:  cfg.kern_last  = val[11:0];
            pfa_pkg::REG_MP_ENTRY:   cfg.mp_entry   = val[11:0];
            default: ;
        endcase
        reg_writes++;
        // Read the register straight back.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (val & mask))
            report_mismatch("register readback", prdata, val & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_config(input int unsigned pc, input int unsigned io_f,
                                input int unsigned io_l, input int unsigned kern_f,
                                input int unsigned kern_l, input int unsigned mp);
        write_reg(pfa_pkg::REG_PAGE_COUNT, pc);
        write_reg(pfa_pkg::REG_IO_FIRST, io_f);
        write_reg(pfa_pkg::REG_IO_LAST, io_l);
        write_reg(pfa_pkg::REG_KERN_FIRST, kern_f);
        write_reg(pfa_pkg::REG_KERN_LAST, kern_l);
        write_reg(pfa_pkg::REG_MP_ENTRY, mp);
    endtask

    function automatic logic [11:0] rand_page_upto(input int unsigned span);
        if ($urandom_range(0, 4) == 0) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, span));
    endfunction

    // A page that is most likely in use, so that frees and count updates mostly succeed.
    function automatic logic [11:0] pick_held_page();
        int k;
        while (held_pages.size() > 0) begin
            k = $urandom_range(0, held_pages.size() - 1);
            if (!pf_free[held_pages[k]]) return held_pages[k];
            held_pages.delete(k);
        end
        return rand_page_upto((cfg.page_count < PAGES) ? cfg.page_count + 1 : PAGES - 1);
    endfunction

    task automatic test_directed();
        t_result r;
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        send_item(3'd5, 12'hFFF, r);
        send_item(3'd6, 12'hAAA, r);
        send_item(3'd7, 12'h555, r);
        send_item(pfa_pkg::OP_INIT, 12'd0, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        send_item(pfa_pkg::OP_FREE, 12'd4095, r);
        send_item(pfa_pkg::OP_FREE, 12'd4095, r);
        send_item(pfa_pkg::OP_INCREF, 12'd4094, r);
        send_item(pfa_pkg::OP_FREE, 12'd4094, r);
        send_item(pfa_pkg::OP_DECREF, 12'd4094, r);
        send_item(pfa_pkg::OP_DECREF, 12'd4094, r);
        // A free page may still be referenced; dropping it to zero must not push it twice.
        send_item(pfa_pkg::OP_INCREF, 12'd4094, r);
        send_item(pfa_pkg::OP_DECREF, 12'd4094, r);
        send_item(pfa_pkg::OP_INCREF, 12'd0, r);
        send_item(pfa_pkg::OP_FREE, 12'd7, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        drain_results();
    endtask

    task automatic test_config_extremes();
        t_result r;
        write_config(0, 0, 0, 0, 0, 0);
        send_item(pfa_pkg::OP_INIT, 12'd0, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        send_item(pfa_pkg::OP_FREE, 12'd0, r);
        drain_results();
        // Everything reserved, and a page count beyond the number of pages.
        write_config(8191, 0, 4095, 4095, 4095, 4095);
        send_item(pfa_pkg::OP_INIT, 12'd0, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        drain_results();
        write_config(8191, 4095, 0, 4095, 4095, 0);
        send_item(pfa_pkg::OP_INIT, 12'd0, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        send_item(pfa_pkg::OP_DECREF, 12'd4095, r);
        drain_results();
    endtask

    task automatic randomise_config();
        int unsigned pc;
        int unsigned span;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            pc = $urandom_range(1, 48);
        else if (pick <= 7)
            pc = $urandom_range(49, 300);
        else if (pick == 8)
            pc = PAGES;
        else
            pc = $urandom_range(0, 8191);
        span = (pc >= PAGES) ? PAGES - 1 : pc + 2;
        write_config(pc, rand_page_upto(span), rand_page_upto(span), rand_page_upto(span),
                     rand_page_upto(span), rand_page_upto(span));
    endtask

    task automatic test_random_traffic(input int n_items);
        t_result r;
        int unsigned roll;
        drain_results();
        randomise_config();
        traffic_phases++;
        send_item(pfa_pkg::OP_INIT, 12'd0, r);
        repeat (n_items - 1) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                send_item(pfa_pkg::OP_ALLOC, 12'($urandom_range(0, 4095)), r);
            else if (roll < 50)
                send_item(pfa_pkg::OP_FREE, pick_held_page(), r);
            else if (roll < 70)
                send_item(pfa_pkg::OP_INCREF, pick_held_page(), r);
            else if (roll < 90)
                send_item(pfa_pkg::OP_DECREF, pick_held_page(), r);
            else if (roll < 95)
                send_item(3'($urandom_range(pfa_pkg::OP_FREE, pfa_pkg::OP_DECREF)),
                          12'($urandom_range(0, 4095)), r);
            else if (roll < 98)
                send_item(3'($urandom_range(5, 7)), 12'($urandom_range(0, 4095)), r);
            else
                send_item(pfa_pkg::OP_INIT, 12'($urandom_range(0, 4095)), r);
        end
        drain_results();
    endtask

    task automatic test_count_climb();
        t_result r;
        logic [11:0] pg;
        write_config(64, 1, 2, 3, 3, 4);
        send_item(pfa_pkg::OP_INIT, 12'd0, r);
        send_item(pfa_pkg::OP_ALLOC, 12'd0, r);
        pg = r.page;
        repeat (20) send_item(pfa_pkg::OP_INCREF, pg, r);
        repeat (3) send_item(pfa_pkg::OP_DECREF, pg, r);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 0);
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[11:0] !== want.page)
                    report_mismatch("result_page", m_axis_tdata[11:0], want.page);
                if (m_axis_tdata[27:12] !== want.count)
                    report_mismatch("ref_count", m_axis_tdata[27:12], want.count);
                if (m_axis_tdata[28] !== want.freed)
                    report_mismatch("freed", m_axis_tdata[28], want.freed);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("** page_frame_allocator_refcount: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 13;
        rx_idle_pct = 45;
        test_directed();
        test_config_extremes();
        repeat (3) test_random_traffic(95);
        tx_idle_pct = 45;
        rx_idle_pct = 13;
        repeat (3) test_random_traffic(95);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (3) test_random_traffic(95);
        test_count_climb();
        repeat (20) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never returned", awaited_results.size(), 0);
        $display("Sent %0d items (%0d inits) over %0d register writes; %0d results checked.",
                 items_sent, inits_sent, reg_writes, results_seen);
        $display("Covered %0d random traffic phases and a reference count climb on one page.",
                 traffic_phases);
        if (mismatches == 0)
            $display("** page_frame_allocator_refcount: PASSED **");
        else
            $display("** page_frame_allocator_refcount: FAILED **");
        $finish;
    end

endmodule
